// ----- hdl/hsl_hue_rotate_color_top_macros.svh -----
// ----------------------------------------------------------------------------
// hsl hue rotate assertion macros
// shared concurrent assertion forms for the hue rotation pipeline
// ----------------------------------------------------------------------------
`ifndef HSL_HUE_ROTATE_COLOR_TOP_MACROS_SVH
`define HSL_HUE_ROTATE_COLOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HRC_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hrc_pkg.sv -----
// ----------------------------------------------------------------------------
// hrc_pkg
// widths, fixed-point constants and shared types of the hue rotation pipeline
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UNIT_W    = FRAC_BITS + 1;
    localparam int DIV_W     = 11;
    localparam int REM_W     = DIV_W + 1;

    localparam int unsigned ONE_I = 32'd1 << FRAC_BITS;

    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [UNIT_W-1:0]    unit_t;

    localparam unit_t FX_ONE        = UNIT_W'(ONE_I);
    localparam unit_t FX_HALF       = UNIT_W'(ONE_I / 2);
    localparam unit_t FX_TWELFTH    = UNIT_W'(ONE_I / 12);
    localparam unit_t FX_SIXTH      = UNIT_W'(ONE_I / 6);
    localparam unit_t FX_THIRD      = UNIT_W'(ONE_I / 3);
    localparam unit_t FX_TWO_THIRDS = UNIT_W'((2 * ONE_I) / 3);

    localparam logic [8:0] HALF_SUM = 9'd255;
    localparam logic [8:0] FULL_SUM = 9'd510;

    typedef struct packed {
        logic       grey;
        logic       right;
        unit_t      lum;
        logic [7:0] comp_red;
        logic [7:0] comp_green;
        logic [7:0] comp_blue;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0] sat_num;
        logic [DIV_W-1:0] sat_den;
        logic [DIV_W-1:0] hue_num;
        logic [DIV_W-1:0] hue_den;
    } div_ops_t;

endpackage

// ----- hdl/hrc_prep.sv -----
// ----------------------------------------------------------------------------
// hrc_prep
// first stage: max, min, delta, lightness, sextant numerator and divider operands
// ----------------------------------------------------------------------------
module hrc_prep (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             s_valid,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,
    input  logic             rotate_right,
    output logic             valid_out,
    output hrc_pkg::side_t    side_out,
    output hrc_pkg::div_ops_t ops_out
);
    import hrc_pkg::*;

    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [7:0]        delta;
    logic [8:0]        sum;
    logic [8:0]        den;
    logic [FRAC_BITS-1:0] lum_y;
    logic [FRAC_BITS:0]   lum_ysum;
    logic signed [11:0] r12, g12, b12, d12, num_s;
    logic [11:0]       d6;
    logic              valid_reg;
    side_t             side_reg, side_next;
    div_ops_t          ops_reg, ops_next;

    always_comb begin
        mx = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx) mx = blue_in;
        mn = red_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn) mn = blue_in;
        delta = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        den   = (sum < HALF_SUM) ? sum : FULL_SUM - sum;
        // lightness sum * ONE / 510 = y + y / 255 with y = sum * ONE / 512
        lum_y    = FRAC_BITS'(sum) << (FRAC_BITS - 9);
        lum_ysum = {1'b0, lum_y} + (FRAC_BITS+1)'(lum_y >> 8) + 1'b1;
        r12   = {4'b0, red_in};
        g12   = {4'b0, green_in};
        b12   = {4'b0, blue_in};
        d12   = {4'b0, delta};
        d6    = 12'((d12 << 2) + (d12 << 1));
        // red wins ties over green, green over blue
        if (mx == red_in) begin
            num_s = (green_in < blue_in ? $signed(d6) : 12'sd0) + g12 - b12;
        end else if (mx == green_in) begin
            num_s = (d12 << 1) + b12 - r12;
        end else begin
            num_s = (d12 << 2) + r12 - g12;
        end

        ops_next.sat_num = DIV_W'(delta);
        ops_next.sat_den = DIV_W'(den);
        ops_next.hue_num = (num_s < 0) ? '0 : num_s[DIV_W-1:0];
        ops_next.hue_den = d6[DIV_W-1:0];

        side_next.grey       = (delta == 8'd0);
        side_next.right      = rotate_right;
        side_next.lum        = {1'b0, lum_y} + UNIT_W'(lum_ysum >> 8);
        side_next.comp_red   = 8'd255 - red_in;
        side_next.comp_green = 8'd255 - green_in;
        side_next.comp_blue  = 8'd255 - blue_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ops_reg  <= ops_next;
            side_reg <= side_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign ops_out   = ops_reg;

endmodule

// ----- hdl/hrc_div.sv -----
// ----------------------------------------------------------------------------
// hrc_div
// pipelined restoring divider, one quotient bit per stage, quotient < 2 ONE
// ----------------------------------------------------------------------------
module hrc_div (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [hrc_pkg::DIV_W-1:0] num_in,
    input  logic [hrc_pkg::DIV_W-1:0] den_in,
    output hrc_pkg::unit_t            quot_out
);
    import hrc_pkg::*;

    logic [REM_W-1:0] rem_reg [UNIT_W];
    logic [DIV_W-1:0] den_reg [UNIT_W];
    unit_t            quo_reg [UNIT_W];

    for (genvar k = 0; k < UNIT_W; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [DIV_W-1:0] den_k;
        unit_t            quo_in;
        logic             ge;
        logic [REM_W-1:0] rem_sub;
        logic [REM_W-1:0] rem_next;
        unit_t            quo_next;

        if (k == 0) begin : g_first
            assign rem_in = {1'b0, num_in};
            assign den_k  = den_in;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_k  = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign ge       = rem_in >= {1'b0, den_k};
        assign rem_sub  = ge ? rem_in - {1'b0, den_k} : rem_in;
        assign rem_next = {rem_sub[REM_W-2:0], 1'b0};
        assign quo_next = {quo_in[UNIT_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_k;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quot_out = quo_reg[UNIT_W-1];

endmodule

// ----- hdl/hrc_mix.sv -----
// ----------------------------------------------------------------------------
// hrc_mix
// hue turn, p and q, per-channel ramps and byte scaling in four stages
// ----------------------------------------------------------------------------
`include "hsl_hue_rotate_color_top_macros.svh"

module hrc_mix (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           valid_in,
    input  hrc_pkg::side_t side_in,
    input  hrc_pkg::unit_t lum_in,
    input  hrc_pkg::unit_t sat_in,
    input  hrc_pkg::unit_t hue_in,
    output logic           valid_out,
    output logic [7:0]     rot_red,
    output logic [7:0]     rot_green,
    output logic [7:0]     rot_blue,
    output logic [7:0]     comp_red,
    output logic [7:0]     comp_green,
    output logic [7:0]     comp_blue
);
    import hrc_pkg::*;

    typedef enum logic [1:0] {
        SEG_UP,
        SEG_Q,
        SEG_DOWN,
        SEG_P
    } seg_t;

    // stage a
    unit_t              sat_m, hue_c, hs;
    frac_t              hue_m, h1_next;
    logic [2*UNIT_W-1:0] ls_prod;
    logic               va_reg;
    side_t              sa_reg;
    unit_t              lum_a_reg, sat_a_reg, ls_a_reg;
    frac_t              h1_a_reg;
    logic               grey_a_reg, lt_a_reg;

    always_comb begin
        sat_m = side_in.grey ? '0 : sat_in;
        hue_c = (hue_in >= FX_ONE) ? FX_ONE - 1'b1 : hue_in;
        hue_m = side_in.grey ? '0 : hue_c[FRAC_BITS-1:0];
        if (side_in.right) begin
            hs = {1'b0, hue_m} + FX_TWELFTH;
            if (hs >= FX_ONE) hs = hs - FX_ONE;
        end else if ({1'b0, hue_m} < FX_TWELFTH) begin
            hs = {1'b0, hue_m} + FX_ONE - FX_TWELFTH;
        end else begin
            hs = {1'b0, hue_m} - FX_TWELFTH;
        end
        h1_next = hs[FRAC_BITS-1:0];
        ls_prod = lum_in * sat_m;
    end

    // stage b
    logic [UNIT_W:0]        q_full;
    logic signed [UNIT_W+2:0] p_s, d_s;
    unit_t                  q_c, p_c, d_c;
    unit_t                  t_ch [3];
    unit_t                  x_next [3];
    seg_t                   seg_next [3];
    logic [UNIT_W+2:0]      x6;
    logic                   vb_reg;
    side_t                  sb_reg;
    unit_t                  p_b_reg, q_b_reg, d_b_reg, lum_b_reg;
    unit_t                  x_b_reg [3];
    seg_t                   seg_b_reg [3];
    logic                   grey_b_reg;

    always_comb begin
        q_full = lt_a_reg ? {1'b0, lum_a_reg} + {1'b0, ls_a_reg}
                          : {1'b0, lum_a_reg} + {1'b0, sat_a_reg} - {1'b0, ls_a_reg};
        p_s = $signed({2'b0, lum_a_reg, 1'b0}) - $signed({2'b0, q_full});
        q_c = (q_full > {1'b0, FX_ONE}) ? FX_ONE : q_full[UNIT_W-1:0];
        p_c = (p_s < 0) ? '0 : p_s[UNIT_W-1:0];
        d_s = $signed({3'b0, q_c}) - $signed({3'b0, p_c});
        d_c = (d_s < 0) ? '0 : d_s[UNIT_W-1:0];

        // red and blue sit one third of a turn either side of green
        t_ch[1] = {1'b0, h1_a_reg};
        t_ch[0] = ({1'b0, h1_a_reg} >= FX_ONE - FX_THIRD)
                ? {1'b0, h1_a_reg} + FX_THIRD - FX_ONE : {1'b0, h1_a_reg} + FX_THIRD;
        t_ch[2] = ({1'b0, h1_a_reg} < FX_THIRD)
                ? {1'b0, h1_a_reg} + FX_ONE - FX_THIRD : {1'b0, h1_a_reg} - FX_THIRD;

        x6 = '0;
        for (int c = 0; c < 3; c++) begin
            if (t_ch[c] < FX_SIXTH) begin
                seg_next[c] = SEG_UP;
                x6 = ({3'b0, t_ch[c]} << 2) + ({3'b0, t_ch[c]} << 1);
            end else if (t_ch[c] < FX_HALF) begin
                seg_next[c] = SEG_Q;
                x6 = '0;
            end else if (t_ch[c] < FX_TWO_THIRDS) begin
                seg_next[c] = SEG_DOWN;
                x6 = ({3'b0, FX_TWO_THIRDS - t_ch[c]} << 2)
                   + ({3'b0, FX_TWO_THIRDS - t_ch[c]} << 1);
            end else begin
                seg_next[c] = SEG_P;
                x6 = '0;
            end
            x_next[c] = x6[UNIT_W-1:0];
        end
    end

    // stage c
    logic [2*UNIT_W-1:0] ramp_prod [3];
    logic [UNIT_W:0]     v_next [3];
    logic                vc_reg;
    side_t               sc_reg;
    logic                grey_c_reg;
    logic [UNIT_W:0]     v_reg [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ramp_prod[c] = d_b_reg * x_b_reg[c];
            case (seg_b_reg[c])
                SEG_UP, SEG_DOWN: v_next[c] = {1'b0, p_b_reg}
                                            + {1'b0, ramp_prod[c][FRAC_BITS +: UNIT_W]};
                SEG_Q:            v_next[c] = {1'b0, q_b_reg};
                SEG_P:            v_next[c] = {1'b0, p_b_reg};
                default:          v_next[c] = {1'b0, p_b_reg};
            endcase
            if (grey_b_reg) v_next[c] = {1'b0, lum_b_reg};
        end
    end

    // stage d: v * 255 as a shift and subtract, then saturate
    logic [UNIT_W+8:0] scaled [3];
    logic [7:0]        byte_next [3];
    logic              vd_reg;
    logic [7:0]        byte_reg [3];
    side_t             sd_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            scaled[c] = {v_reg[c], 8'b0} - {8'b0, v_reg[c]};
            byte_next[c] = (scaled[c][UNIT_W+8:FRAC_BITS] > 10'd255)
                         ? 8'd255 : scaled[c][FRAC_BITS +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg     <= side_in;
            lum_a_reg  <= lum_in;
            sat_a_reg  <= sat_m;
            ls_a_reg   <= ls_prod[FRAC_BITS +: UNIT_W];
            h1_a_reg   <= h1_next;
            grey_a_reg <= (sat_m == '0);
            lt_a_reg   <= (lum_in < FX_HALF);

            sb_reg     <= sa_reg;
            p_b_reg    <= p_c;
            q_b_reg    <= q_c;
            d_b_reg    <= d_c;
            lum_b_reg  <= lum_a_reg;
            grey_b_reg <= grey_a_reg;
            for (int c = 0; c < 3; c++) begin
                x_b_reg[c]   <= x_next[c];
                seg_b_reg[c] <= seg_next[c];
            end

            sc_reg     <= sb_reg;
            grey_c_reg <= grey_b_reg;
            for (int c = 0; c < 3; c++) begin
                v_reg[c] <= v_next[c];
            end

            sd_reg <= sc_reg;
            for (int c = 0; c < 3; c++) begin
                byte_reg[c] <= byte_next[c];
            end
        end
    end

    assign valid_out  = vd_reg;
    assign rot_red    = byte_reg[0];
    assign rot_green  = byte_reg[1];
    assign rot_blue   = byte_reg[2];
    assign comp_red   = sd_reg.comp_red;
    assign comp_green = sd_reg.comp_green;
    assign comp_blue  = sd_reg.comp_blue;

    `HRC_ASSERT(a_grey_channels_equal, aclk, aresetn, vc_reg && grey_c_reg,
        (v_reg[0] == v_reg[1]) && (v_reg[1] == v_reg[2]), "grey pixel channels differ")
    `HRC_ASSERT(a_q_not_below_p, aclk, aresetn, vb_reg, q_b_reg >= p_b_reg,
        "q fell below p")
    `HRC_ASSERT(a_ramp_in_range, aclk, aresetn, vb_reg,
        (x_b_reg[0] <= FX_ONE) && (x_b_reg[1] <= FX_ONE) && (x_b_reg[2] <= FX_ONE),
        "ramp position beyond one")

endmodule

// ----- hdl/hsl_hue_rotate_color_top.sv -----
// ----------------------------------------------------------------------------
// hsl_hue_rotate_color_top
// rgb to hsl, hue turned by 30 degrees, back to rgb, plus complement colour
// ----------------------------------------------------------------------------
//  channel  ports                                       direction
//  s_       s_red_in s_green_in s_blue_in s_rotate_right in, valid/ready
//  m_       m_rot_* (r,g,b) m_comp_* (r,g,b)             out, valid/ready
//
//  one pixel per clock while the output is not stalled
//  the bit-per-stage dividers for saturation and hue set the depth
//  all stages advance together; a stall at m_ holds every stage and s_ready
//  aresetn is synchronous, active low, and clears only the valid bits
// ----------------------------------------------------------------------------
`include "hsl_hue_rotate_color_top_macros.svh"

module hsl_hue_rotate_color_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_blue_in,
    input  logic       s_rotate_right,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_rot_red,
    output logic [7:0] m_rot_green,
    output logic [7:0] m_rot_blue,
    output logic [7:0] m_comp_red,
    output logic [7:0] m_comp_green,
    output logic [7:0] m_comp_blue
);
    import hrc_pkg::*;

    logic     pipe_en;
    logic     prep_valid;
    side_t    prep_side;
    div_ops_t prep_ops;
    unit_t    sat_q, hue_q;
    logic     vld_reg [UNIT_W];
    side_t    side_reg [UNIT_W];

    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    hrc_prep u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (pipe_en),
        .s_valid      (s_valid),
        .red_in       (s_red_in),
        .green_in     (s_green_in),
        .blue_in      (s_blue_in),
        .rotate_right (s_rotate_right),
        .valid_out    (prep_valid),
        .side_out     (prep_side),
        .ops_out      (prep_ops)
    );

    hrc_div u_div_sat (
        .aclk     (aclk),
        .en       (pipe_en),
        .num_in   (prep_ops.sat_num),
        .den_in   (prep_ops.sat_den),
        .quot_out (sat_q)
    );

    hrc_div u_div_hue (
        .aclk     (aclk),
        .en       (pipe_en),
        .num_in   (prep_ops.hue_num),
        .den_in   (prep_ops.hue_den),
        .quot_out (hue_q)
    );

    // side data and valid bits keep pace with the dividers
    for (genvar k = 0; k < UNIT_W; k++) begin : g_side
        logic  vld_next;
        side_t side_next;
        if (k == 0) begin : g_first
            assign vld_next  = prep_valid;
            assign side_next = prep_side;
        end else begin : g_rest
            assign vld_next  = vld_reg[k-1];
            assign side_next = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                vld_reg[k] <= vld_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                side_reg[k] <= side_next;
            end
        end
    end

    hrc_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .valid_in   (vld_reg[UNIT_W-1]),
        .side_in    (side_reg[UNIT_W-1]),
        .lum_in     (side_reg[UNIT_W-1].lum),
        .sat_in     (sat_q),
        .hue_in     (hue_q),
        .valid_out  (m_valid),
        .rot_red    (m_rot_red),
        .rot_green  (m_rot_green),
        .rot_blue   (m_rot_blue),
        .comp_red   (m_comp_red),
        .comp_green (m_comp_green),
        .comp_blue  (m_comp_blue)
    );

    `HRC_ASSERT(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready,
        "input blocked with empty output")
    `HRC_ASSERT(a_lum_in_range, aclk, aresetn, vld_reg[UNIT_W-1],
        side_reg[UNIT_W-1].lum <= FX_ONE, "lightness above one")
    `HRC_ASSERT(a_sat_in_range, aclk, aresetn,
        vld_reg[UNIT_W-1] && !side_reg[UNIT_W-1].grey,
        (sat_q <= FX_ONE) && (sat_q != '0), "saturation out of range")
    `HRC_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !pipe_en,
        $stable(sat_q) && $stable(hue_q) && $stable(vld_reg[UNIT_W-1]),
        "pipeline moved during a stall")

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the hue rotation pipeline: a table of directed pixels, then random
// pixels under bursty input and stalling output, each transfer compared with
// a fixed expected colour or a fixed-point model of the rgb-hsl-rgb hue turn and the complement colour
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrc_pkg::*;

    localparam int N_RANDOM    = 850;
    localparam int WATCHDOG    = 20000;
    localparam int DRAIN_WAIT  = FRAC_BITS + 16;
    localparam longint ONE     = longint'(1) << FRAC_BITS;
    localparam longint TWELFTH = ONE / 12;
    localparam longint SIXTH   = ONE / 6;
    localparam longint THIRD   = ONE / 3;
    localparam longint TWO_THD = (2 * ONE) / 3;

    typedef struct packed {
        logic [7:0] rr, rg, rb, cr, cg, cb;
    } color_out_t;

    typedef struct {
        logic [7:0] r, g, b;
        logic       right;
        logic       has_fixed;
        color_out_t fixed;
    } pixel_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_red_in = '0, s_green_in = '0, s_blue_in = '0;
    logic       s_rotate_right = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_rot_red, m_rot_green, m_rot_blue;
    logic [7:0] m_comp_red, m_comp_green, m_comp_blue;

    color_out_t expected_colors[$];
    int         n_errors = 0;
    int         n_checked = 0;
    int         idle_cycles = 0;
    bit         stim_done = 1'b0;
    pixel_row_t rows[$];

    hsl_hue_rotate_color_top u_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint hue_channel(longint t, longint p, longint q);
        longint d;
        d = q - p;
        if (t < 0) t += ONE;
        if (t >= ONE) t -= ONE;
        if (d < 0) d = 0;
        if (t < SIXTH) return p + ((d * 6 * t) >>> FRAC_BITS);
        if (t < ONE / 2) return q;
        if (t < TWO_THD) return p + ((d * 6 * (TWO_THD - t)) >>> FRAC_BITS);
        return p;
    endfunction

    function automatic logic [7:0] frac_to_byte(longint v);
        longint x;
        if (v < 0) v = 0;
        x = (v * 255) >>> FRAC_BITS;
        return (x > 255) ? 8'd255 : 8'(x);
    endfunction

    function automatic color_out_t rotate_hue(logic [7:0] r8, logic [7:0] g8,
                                              logic [7:0] b8, logic right);
        longint r, g, b, mx, mn, delta, sum, lum, sat, hue, h1, den, num, ls, q, p;
        color_out_t o;
        r = r8; g = g8; b = b8;
        sat = 0; hue = 0;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        sum = mx + mn;
        lum = (sum * ONE) / 510;
        if (delta != 0) begin
            den = (lum < ONE / 2) ? sum : 510 - sum;
            if (den > 0) sat = (delta * ONE) / den;
            if (mx == r) num = ((g < b) ? 6 * delta : 0) + (g - b);
            else if (mx == g) num = 2 * delta + (b - r);
            else num = 4 * delta + (r - g);
            if (num < 0) num = 0;
            hue = (num * ONE) / (6 * delta);
            if (hue >= ONE) hue = ONE - 1;
        end
        if (right) begin
            h1 = hue + TWELFTH;
            if (h1 >= ONE) h1 -= ONE;
        end else begin
            h1 = (hue < TWELFTH) ? hue + ONE - TWELFTH : hue - TWELFTH;
        end
        if (sat == 0) begin
            o.rr = frac_to_byte(lum);
            o.rg = o.rr;
            o.rb = o.rr;
        end else begin
            ls = (lum * sat) >>> FRAC_BITS;
            q = (lum < ONE / 2) ? lum + ls : lum + sat - ls;
            p = 2 * lum - q;
            if (q > ONE) q = ONE;
            if (p < 0) p = 0;
            o.rr = frac_to_byte(hue_channel(h1 + THIRD, p, q));
            o.rg = frac_to_byte(hue_channel(h1, p, q));
            o.rb = frac_to_byte(hue_channel(h1 - THIRD, p, q));
        end
        o.cr = 8'd255 - r8;
        o.cg = 8'd255 - g8;
        o.cb = 8'd255 - b8;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic right,
                           logic has_fixed = 1'b0, color_out_t fixed = '0);
        pixel_row_t row;
        row.r = r; row.g = g; row.b = b; row.right = right;
        row.has_fixed = has_fixed; row.fixed = fixed;
        rows.push_back(row);
    endtask

    // receiver: stall pattern plus result checking
    int stall_phase = 0;
    always @(posedge aclk) begin
        color_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    n_errors++;
                    $display("unexpected transfer at %0t", $realtime);
                end else begin
                    want = expected_colors.pop_front();
                    n_checked++;
                    if (m_rot_red !== want.rr) report_mismatch("rot_red", m_rot_red, want.rr);
                    if (m_rot_green !== want.rg)
                        report_mismatch("rot_green", m_rot_green, want.rg);
                    if (m_rot_blue !== want.rb) report_mismatch("rot_blue", m_rot_blue, want.rb);
                    if (m_comp_red !== want.cr) report_mismatch("comp_red", m_comp_red, want.cr);
                    if (m_comp_green !== want.cg)
                        report_mismatch("comp_green", m_comp_green, want.cg);
                    if (m_comp_blue !== want.cb)
                        report_mismatch("comp_blue", m_comp_blue, want.cb);
                end
            end
            stall_phase <= stall_phase + 1;
            // free-running stretches alternate with random stalls
            if (stall_phase % 200 < 60) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired at %0t", $realtime);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        color_out_t fx;
        int burst, k, gap;
        logic [7:0] v;
        // grey extremes: black, white, mid grey
        fx = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
        add_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, fx);
        add_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b1, fx);
        fx = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
        add_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, fx);
        add_row(8'd128, 8'd128, 8'd128, 1'b0);
        // primaries in both directions, secondaries in one each; includes max ties
        add_row(8'd255, 8'd0, 8'd0, 1'b1);
        add_row(8'd255, 8'd0, 8'd0, 1'b0);
        add_row(8'd0, 8'd255, 8'd0, 1'b1);
        add_row(8'd0, 8'd255, 8'd0, 1'b0);
        add_row(8'd0, 8'd0, 8'd255, 1'b1);
        add_row(8'd0, 8'd0, 8'd255, 1'b0);
        add_row(8'd255, 8'd255, 8'd0, 1'b1);
        add_row(8'd0, 8'd255, 8'd255, 1'b0);
        add_row(8'd255, 8'd0, 8'd255, 1'b1);
        // red max with green below blue: hue just under one turn, wraps right
        add_row(8'd255, 8'd0, 8'd1, 1'b1);
        // hue just above zero, wraps left
        add_row(8'd255, 8'd1, 8'd0, 1'b0);
        // low and high lightness, tiny delta
        add_row(8'd1, 8'd0, 8'd0, 1'b1);
        add_row(8'd255, 8'd254, 8'd254, 1'b0);
        add_row(8'd200, 8'd100, 8'd50, 1'b1);
        add_row(8'd50, 8'd100, 8'd200, 1'b0);
        add_row(8'd170, 8'd85, 8'd85, 1'b1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        k = 0;
        while (k < rows.size() + N_RANDOM) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && k < rows.size() + N_RANDOM; j++) begin
                if (k < rows.size()) begin
                    s_red_in <= rows[k].r;
                    s_green_in <= rows[k].g;
                    s_blue_in <= rows[k].b;
                    s_rotate_right <= rows[k].right;
                    fx = rows[k].has_fixed ? rows[k].fixed
                         : rotate_hue(rows[k].r, rows[k].g, rows[k].b, rows[k].right);
                end else begin
                    // mostly full range, red sometimes held to a narrow mid band
                    s_red_in <= ($urandom_range(0, 3) == 0) ? 8'($urandom_range(120, 124))
                                                             : 8'($urandom);
                    s_green_in <= 8'($urandom);
                    s_blue_in <= 8'($urandom);
                    s_rotate_right <= 1'($urandom);
                    #0;
                end
                s_valid <= 1'b1;
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                if (k >= rows.size())
                    fx = rotate_hue(s_red_in, s_green_in, s_blue_in, s_rotate_right);
                expected_colors.push_back(fx);
                k++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
        while (expected_colors.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("checked %0d pixels: %0d directed, %0d random, both rotations",
                 n_checked, rows.size(), N_RANDOM);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- hsl_hue_rotate_color_top.f -----
+incdir+hdl
hdl/hrc_pkg.sv
hdl/hrc_prep.sv
hdl/hrc_div.sv
hdl/hrc_mix.sv
hdl/hsl_hue_rotate_color_top.sv
bench/tb_top.sv
